FILE: rtl/core/sliding_window_max_min_sum_unit_assert.svh
// Assertion macros shared by the sliding window unit.
`ifndef SLIDING_WINDOW_MAX_MIN_SUM_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_MAX_MIN_SUM_UNIT_ASSERT_SVH

// Holds at every clock edge outside reset.
`define SWMM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define SWMM_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: rtl/core/swmm_pkg.sv
package swmm_pkg;

   localparam int WINDOW_MAX  = 32;
   localparam int SAMPLE_BITS = 16;
   localparam int TOTAL_BITS  = 48;
   localparam int SIZE_BITS   = $clog2(WINDOW_MAX + 1);
   localparam int CNT_BITS    = $clog2(WINDOW_MAX);
   localparam int CSR_BITS    = 6;
   localparam int SUM_BITS    = TOTAL_BITS + 2;
   localparam logic [SIZE_BITS-1:0] K_RESET = SIZE_BITS'(4);

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          last_sample;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] window_max;
      logic signed [SAMPLE_BITS-1:0] window_min;
      logic signed [TOTAL_BITS-1:0]  running_total;
      logic                          total_saturated;
      logic                          end_of_set;
   } rsp_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic signed [SAMPLE_BITS-1:0] mx;
      logic signed [SAMPLE_BITS-1:0] mn;
   } link_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_ACCUM
   } state_type;

endpackage

FILE: rtl/core/swmm_cell.sv
module swmm_cell (
   input  logic              clock,
   input  logic              shift_en,
   input  logic              in_window,
   input  swmm_pkg::link_type prev,
   output swmm_pkg::link_type next
);
   import swmm_pkg::*;

   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic signed [SAMPLE_BITS-1:0] mx_ff, mx_in;
   logic signed [SAMPLE_BITS-1:0] mn_ff, mn_in;

   always_comb begin
      sample_in = shift_en ? $signed(prev.sample) : sample_ff;
      mx_in     = $signed(prev.mx);
      mn_in     = $signed(prev.mn);
      if (in_window && (sample_ff > $signed(prev.mx))) begin
         mx_in = sample_ff;
      end
      if (in_window && (sample_ff < $signed(prev.mn))) begin
         mn_in = sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      mx_ff     <= mx_in;
      mn_ff     <= mn_in;
   end

   assign next.sample = sample_ff;
   assign next.mx     = mx_ff;
   assign next.mn     = mn_ff;

endmodule

FILE: rtl/core/sliding_window_max_min_sum_unit.sv
// Sliding window maximum and minimum with a saturating running total.
// Samples arrive on the req_ channel (valid/ready) and results leave on the
// rsp_ channel (valid/ready). The csr_ port sets the window size; zero acts
// as one and sizes above 32 act as 32. Write it only while the unit is idle.
// Each accepted item shifts into a chain of 32 cells. When the set holds a
// full window, a max/min wave runs down the chain, one cell a cycle, while
// the unit waits in the sweep state; the accumulate state then updates the
// total and loads the result once the output register is free. No new item
// is taken before that. An item that yields no result leaves the unit idle.
// An item marked last closes the set and clears the count and the total.
// A result that the receiver stalls waits in the output register; the next
// item is still accepted, and its own result waits for the register to free.
// Synchronous reset clears the set, sets a window of four and empties the
// output; held samples are only read once written in the current set.
module sliding_window_max_min_sum_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  swmm_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output swmm_pkg::rsp_type                 rsp_data,
   input  logic                              csr_wr_en,
   input  logic [swmm_pkg::CSR_BITS-1:0]     csr_wr_data
);
   import swmm_pkg::*;

   state_type              state_ff, state_in;
   logic [SIZE_BITS-1:0]   k_ff, k_in;
   logic [SIZE_BITS-1:0]   fill_ff, fill_in, fill_inc;
   logic [CNT_BITS-1:0]    sweep_ff, sweep_in;
   logic signed [TOTAL_BITS-1:0] total_ff, total_in, total_new;
   logic                   sat_ff, sat_in, sat_new;
   logic                   last_ff, last_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   accept, start_sweep, sweep_done, rsp_load;
   logic signed [SUM_BITS-1:0] sum_w;
   link_type               link [WINDOW_MAX+1];
   logic [WINDOW_MAX-1:0]  in_window;

   // Cell chain.
   assign link[0].sample = req_data.sample;
   assign link[0].mx     = link[1].sample;
   assign link[0].mn     = link[1].sample;

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      assign in_window[i] = SIZE_BITS'(i) < k_ff;
      swmm_cell u_cell (
         .clock     (clock),
         .shift_en  (accept),
         .in_window (in_window[i]),
         .prev      (link[i]),
         .next      (link[i+1])
      );
   end

   // Handshake and sequencing.
   assign accept      = req_valid && req_ready;
   assign fill_inc    = (fill_ff == SIZE_BITS'(WINDOW_MAX)) ? fill_ff : fill_ff + 1'b1;
   assign start_sweep = accept && (fill_inc >= k_ff);
   assign sweep_done  = sweep_ff == CNT_BITS'(WINDOW_MAX - 1);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start_sweep) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (sweep_done) begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      sweep_in  = '0;
      case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_SWEEP: sweep_in  = sweep_ff + 1'b1;
         ST_ACCUM: rsp_load  = !rsp_valid_ff || rsp_ready;
         default:  req_ready = 1'b0;
      endcase
   end

   // Saturating total.
   assign sum_w = SUM_BITS'(total_ff) + SUM_BITS'($signed(link[WINDOW_MAX].mx))
                + SUM_BITS'($signed(link[WINDOW_MAX].mn));

   always_comb begin
      total_new = sum_w[TOTAL_BITS-1:0];
      sat_new   = sat_ff;
      if (sum_w[SUM_BITS-1:TOTAL_BITS-1] != '0 && sum_w[SUM_BITS-1:TOTAL_BITS-1] != '1) begin
         sat_new   = 1'b1;
         total_new = sum_w[SUM_BITS-1] ? {1'b1, {(TOTAL_BITS-1){1'b0}}}
                                       : {1'b0, {(TOTAL_BITS-1){1'b1}}};
      end
   end

   always_comb begin
      k_in         = k_ff;
      fill_in      = fill_ff;
      total_in     = total_ff;
      sat_in       = sat_ff;
      last_in      = last_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (csr_wr_en) begin
         if (csr_wr_data == '0) begin
            k_in = SIZE_BITS'(1);
         end else if (SIZE_BITS'(csr_wr_data) > SIZE_BITS'(WINDOW_MAX)) begin
            k_in = SIZE_BITS'(WINDOW_MAX);
         end else begin
            k_in = SIZE_BITS'(csr_wr_data);
         end
      end
      if (accept) begin
         last_in = req_data.last_sample;
         if (req_data.last_sample && !start_sweep) begin
            fill_in  = '0;
            total_in = '0;
            sat_in   = 1'b0;
         end else begin
            fill_in = fill_inc;
         end
      end
      if (rsp_load) begin
         rsp_valid_in           = 1'b1;
         rsp_in.window_max      = link[WINDOW_MAX].mx;
         rsp_in.window_min      = link[WINDOW_MAX].mn;
         rsp_in.running_total   = total_new;
         rsp_in.total_saturated = sat_new;
         rsp_in.end_of_set      = last_ff;
         if (last_ff) begin
            fill_in  = '0;
            total_in = '0;
            sat_in   = 1'b0;
         end else begin
            total_in = total_new;
            sat_in   = sat_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= K_RESET;
         fill_ff      <= '0;
         sweep_ff     <= '0;
         total_ff     <= '0;
         sat_ff       <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         fill_ff      <= fill_in;
         sweep_ff     <= sweep_in;
         total_ff     <= total_in;
         sat_ff       <= sat_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`include "sliding_window_max_min_sum_unit_assert.svh"

   `SWMM_ASSERT(a_k_range, (k_ff != '0) && (k_ff <= SIZE_BITS'(WINDOW_MAX)), "bad window size")
   `SWMM_ASSERT(a_fill_range, fill_ff <= SIZE_BITS'(WINDOW_MAX), "fill count out of range")
   `SWMM_ASSERT_NEXT(a_sweep_len, state_ff == ST_SWEEP && !sweep_done, state_ff == ST_SWEEP, "short sweep")
   `SWMM_ASSERT(a_rsp_source, $rose(rsp_valid_ff) |-> $past(state_ff == ST_ACCUM), "stray result")

endmodule

FILE: test/tb_top.sv
module tb_top;
   import swmm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 300;
   localparam int PHASE_ITEMS   = 26;
   localparam int PHASE_COUNT   = 12;
   localparam longint TOTAL_HI  = (longint'(1) <<< (TOTAL_BITS - 1)) - 1;
   localparam longint TOTAL_LO  = -TOTAL_HI - 1;
   localparam logic [CSR_BITS-1:0] PHASE_SIZES [PHASE_COUNT] =
      '{0, 1, 2, 3, 5, 8, 16, 31, 32, 33, 63, 4};

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   req_type           req_data    = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   rsp_type           rsp_data;
   logic              csr_wr_en   = 1'b0;
   logic [CSR_BITS-1:0] csr_wr_data = '0;

   req_type pending_samples[$];
   rsp_type expected_results[$];

   // Shadow of the window state.
   logic signed [SAMPLE_BITS-1:0] held_samples [WINDOW_MAX];
   int                  held_count   = 0;
   longint              total_sum    = 0;
   bit                  total_clamped = 1'b0;
   logic [CSR_BITS-1:0] window_size_q = CSR_BITS'(4);

   int  mismatches   = 0;
   int  send_gap     = 0;
   bit  send_burst   = 1'b0;
   int  hold_left    = 0;
   bit  hold_burst   = 1'b0;
   bit  hold_request = 1'b0;
   bit  hold_done    = 1'b0;
   int  quiet_cycles = 0;

   always #5ns clock = ~clock;

   sliding_window_max_min_sum_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   task automatic report_mismatch(string what);
      if (mismatches < 100) begin
         $display("%0t mismatch: %s", $realtime, what);
      end
      mismatches++;
   endtask

   function automatic void window_step(req_type item);
      int                            span;
      logic signed [SAMPLE_BITS-1:0] hi;
      logic signed [SAMPLE_BITS-1:0] lo;
      longint                        acc;
      rsp_type                       res;
      span = int'(window_size_q);
      if (span == 0) begin
         span = 1;
      end
      if (span > WINDOW_MAX) begin
         span = WINDOW_MAX;
      end
      for (int i = WINDOW_MAX - 1; i > 0; i--) begin
         held_samples[i] = held_samples[i-1];
      end
      held_samples[0] = item.sample;
      if (held_count < WINDOW_MAX) begin
         held_count++;
      end
      if (held_count >= span) begin
         hi = held_samples[0];
         lo = held_samples[0];
         for (int i = 1; i < span; i++) begin
            if (held_samples[i] > hi) begin
               hi = held_samples[i];
            end
            if (held_samples[i] < lo) begin
               lo = held_samples[i];
            end
         end
         acc = total_sum + longint'(hi) + longint'(lo);
         if (acc > TOTAL_HI) begin
            acc = TOTAL_HI;
            total_clamped = 1'b1;
         end else if (acc < TOTAL_LO) begin
            acc = TOTAL_LO;
            total_clamped = 1'b1;
         end
         total_sum = acc;
         res.window_max      = hi;
         res.window_min      = lo;
         res.running_total   = TOTAL_BITS'(acc);
         res.total_saturated = total_clamped;
         res.end_of_set      = item.last_sample;
         expected_results = {expected_results, res};
      end
      if (item.last_sample) begin
         held_count    = 0;
         total_sum     = 0;
         total_clamped = 1'b0;
      end
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] draw_sample();
      case ($urandom_range(0, 7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return SAMPLE_BITS'($urandom_range(0, 15));
         3: return -SAMPLE_BITS'($urandom_range(1, 16));
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   task automatic push_item(logic [SAMPLE_BITS-1:0] value, bit closes);
      req_type item;
      item.sample      = value;
      item.last_sample = closes;
      pending_samples = {pending_samples, item};
   endtask

   task automatic queue_set(int len, bit closes);
      for (int i = 0; i < len; i++) begin
         push_item(draw_sample(), closes && (i == len - 1));
      end
   endtask

   task automatic wait_until_drained();
      do begin
         @(negedge clock);
      end while (pending_samples.size() != 0 || req_valid || expected_results.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_window_size(logic [CSR_BITS-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      window_size_q = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Sender: presents pending items and updates the shadow state on acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            window_step(req_data);
            send_gap = send_burst ? 0 : $urandom_range(0, 3);
            if ($urandom_range(0, 19) == 0) begin
               send_burst = !send_burst;
            end
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
               req_data  <= pending_samples[0];
               pending_samples.delete(0);
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each result item against the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result item with no expectation waiting");
            end else begin
               want = expected_results[0];
               expected_results.delete(0);
               if (rsp_data.window_max !== want.window_max) begin
                  report_mismatch($sformatf("window_max got %0d expected %0d",
                     rsp_data.window_max, want.window_max));
               end
               if (rsp_data.window_min !== want.window_min) begin
                  report_mismatch($sformatf("window_min got %0d expected %0d",
                     rsp_data.window_min, want.window_min));
               end
               if (rsp_data.running_total !== want.running_total) begin
                  report_mismatch($sformatf("running_total got %0d expected %0d",
                     rsp_data.running_total, want.running_total));
               end
               if (rsp_data.total_saturated !== want.total_saturated) begin
                  report_mismatch($sformatf("total_saturated got %b expected %b",
                     rsp_data.total_saturated, want.total_saturated));
               end
               if (rsp_data.end_of_set !== want.end_of_set) begin
                  report_mismatch($sformatf("end_of_set got %b expected %b",
                     rsp_data.end_of_set, want.end_of_set));
               end
            end
            hold_left = hold_burst ? 0 : $urandom_range(0, 3);
            if ($urandom_range(0, 19) == 0) begin
               hold_burst = !hold_burst;
            end
         end
         if (hold_request && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      int                  span;
      int                  filled;
      int                  len;
      bit                  closes;
      logic [CSR_BITS-1:0] size;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed sets with the window size left at its reset value.
      push_item(16'd100, 1'b0);
      push_item(-16'sd100, 1'b1);
      push_item(16'h7FFF, 1'b0);
      push_item(16'h8000, 1'b0);
      push_item(16'h0000, 1'b0);
      push_item(16'hFFFF, 1'b1);
      push_item(16'h5555, 1'b0);
      push_item(16'hAAAA, 1'b0);
      push_item(16'h7FFF, 1'b0);
      push_item(16'h7FFF, 1'b0);
      push_item(16'h8000, 1'b0);
      push_item(16'h8000, 1'b0);
      push_item(16'h0001, 1'b0);
      push_item(16'hFFFF, 1'b1);
      push_item(16'd5, 1'b1);
      push_item(16'd1, 1'b0);
      push_item(16'd2, 1'b0);
      push_item(16'd3, 1'b0);
      push_item(16'd4, 1'b0);
      push_item(16'd5, 1'b0);
      wait_until_drained();

      // The window shrinks part way through an open set.
      write_window_size(CSR_BITS'(2));
      @(negedge clock);
      push_item(-16'sd3, 1'b0);
      push_item(16'd9, 1'b1);
      wait_until_drained();
      write_window_size(CSR_BITS'(0));
      @(negedge clock);
      push_item(16'd8, 1'b0);
      push_item(-16'sd8, 1'b1);
      wait_until_drained();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         size = (p == PHASE_COUNT - 1) ? CSR_BITS'($urandom_range(1, 63)) : PHASE_SIZES[p];
         write_window_size(size);
         span = (size == 0) ? 1 : ((int'(size) > WINDOW_MAX) ? WINDOW_MAX : int'(size));
         @(negedge clock);
         filled = 0;
         while (filled < PHASE_ITEMS) begin
            if ($urandom_range(0, 4) == 0) begin
               len = $urandom_range(1, span);
            end else begin
               len = span + $urandom_range(0, 12);
            end
            closes = (filled + len >= PHASE_ITEMS) ? ($urandom_range(0, 2) != 0) : 1'b1;
            queue_set(len, closes);
            filled += len;
         end
         if (p == 3) begin
            hold_request = 1'b1;
         end
         wait_until_drained();
      end

      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/swmm_pkg.sv
rtl/core/swmm_cell.sv
rtl/core/sliding_window_max_min_sum_unit.sv
test/tb_top.sv
